/* rtl/gtp_pkg.sv */
package gtp_pkg;

    // Character codes, carried at the full input width.
    localparam logic [15:0] CH_LBRACE = 16'h007B;
    localparam logic [15:0] CH_RBRACE = 16'h007D;
    localparam logic [15:0] CH_DASH   = 16'h002D;
    localparam logic [15:0] CH_DIG0   = 16'h0030;
    localparam logic [15:0] CH_DIG9   = 16'h0039;
    localparam logic [15:0] CH_UPPA   = 16'h0041;
    localparam logic [15:0] CH_UPPF   = 16'h0046;
    localparam logic [15:0] CH_LOWA   = 16'h0061;
    localparam logic [15:0] CH_LOWF   = 16'h0066;

    // Text layout.
    localparam logic [5:0] BODY_LEN    = 6'd36;
    localparam logic [5:0] BRACED_LEN  = 6'd38;
    localparam logic [5:0] POS_MAX     = 6'd63;
    localparam logic [5:0] DASH_POS_A  = 6'd8;
    localparam logic [5:0] DASH_POS_B  = 6'd13;
    localparam logic [5:0] DASH_POS_C  = 6'd18;
    localparam logic [5:0] DASH_POS_D  = 6'd23;
    localparam logic [5:0] VERSION_POS = 6'd14;
    localparam logic [5:0] VARIANT_POS = 6'd19;

    // Allowed digit ranges for the version and variant positions.
    localparam logic [3:0] VERSION_MIN = 4'd1;
    localparam logic [3:0] VERSION_MAX = 4'd5;
    localparam logic [3:0] VARIANT_MIN = 4'd8;
    localparam logic [3:0] VARIANT_MAX = 4'd11;

    typedef struct packed {
        logic [15:0] text_char;
        logic        is_last;
    } t_in;

    typedef struct packed {
        logic        valid_res;
        logic [63:0] guid_upper;
        logic [63:0] guid_lower;
    } t_out;

    // Verdict on one character, from the checker to the state logic.
    typedef struct packed {
        logic       braced;
        logic       char_ok;
        logic       shift_en;
        logic [3:0] digit;
        logic       length_ok;
    } t_chk;

endpackage

/* rtl/gtp_char_check.sv */
module gtp_char_check (
    input  logic [15:0]   i_text_char,
    input  logic [5:0]    i_pos,
    input  logic          i_braced,
    output gtp_pkg::t_chk o_chk
);

    logic       braced;
    logic [5:0] total;
    logic [5:0] body_idx;
    logic       is_ascii;
    logic       hex_ok;
    logic [3:0] digit;
    logic       dash_slot;
    logic       range_ok;
    logic       body_ok;
    logic       in_range;
    logic       open_slot;
    logic       close_slot;
    logic [6:0] pos_inc;

    always_comb begin
        braced   = i_braced | ((i_pos == 6'd0) && (i_text_char == gtp_pkg::CH_LBRACE));
        total    = braced ? gtp_pkg::BRACED_LEN : gtp_pkg::BODY_LEN;
        body_idx = braced ? (i_pos - 6'd1) : i_pos;
        is_ascii = (i_text_char[15:7] == 9'd0);
        in_range = is_ascii && (i_pos < total);
        open_slot  = braced && (i_pos == 6'd0);
        close_slot = braced && (i_pos == (gtp_pkg::BRACED_LEN - 6'd1));

        hex_ok = 1'b1;
        digit  = 4'd0;
        if ((i_text_char >= gtp_pkg::CH_DIG0) && (i_text_char <= gtp_pkg::CH_DIG9)) begin
            digit = 4'(i_text_char - gtp_pkg::CH_DIG0);
        end else if ((i_text_char >= gtp_pkg::CH_UPPA) && (i_text_char <= gtp_pkg::CH_UPPF)) begin
            digit = 4'(i_text_char - gtp_pkg::CH_UPPA) + 4'd10;
        end else if ((i_text_char >= gtp_pkg::CH_LOWA) && (i_text_char <= gtp_pkg::CH_LOWF)) begin
            digit = 4'(i_text_char - gtp_pkg::CH_LOWA) + 4'd10;
        end else begin
            hex_ok = 1'b0;
        end

        dash_slot = (body_idx == gtp_pkg::DASH_POS_A) || (body_idx == gtp_pkg::DASH_POS_B) ||
                    (body_idx == gtp_pkg::DASH_POS_C) || (body_idx == gtp_pkg::DASH_POS_D);

        range_ok = 1'b1;
        if (body_idx == gtp_pkg::VERSION_POS) begin
            range_ok = (digit >= gtp_pkg::VERSION_MIN) && (digit <= gtp_pkg::VERSION_MAX);
        end else if (body_idx == gtp_pkg::VARIANT_POS) begin
            range_ok = (digit >= gtp_pkg::VARIANT_MIN) && (digit <= gtp_pkg::VARIANT_MAX);
        end

        body_ok = dash_slot ? (i_text_char == gtp_pkg::CH_DASH) : (hex_ok && range_ok);

        o_chk.braced   = braced;
        o_chk.digit    = digit;
        o_chk.shift_en = in_range && !open_slot && !close_slot && !dash_slot && body_ok;
        if (!in_range) begin
            o_chk.char_ok = 1'b0;
        end else if (open_slot) begin
            o_chk.char_ok = 1'b1;
        end else if (close_slot) begin
            o_chk.char_ok = (i_text_char == gtp_pkg::CH_RBRACE);
        end else begin
            o_chk.char_ok = body_ok;
        end

        pos_inc         = {1'b0, i_pos} + 7'd1;
        o_chk.length_ok = (pos_inc == {1'b0, total});
    end

endmodule

/* rtl/gtp_out_reg.sv */
module gtp_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  gtp_pkg::t_out i_data,
    output logic          o_blocked,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output gtp_pkg::t_out o_out_data
);

    logic          r_valid;
    logic          n_valid;
    gtp_pkg::t_out r_data;

    // The register is blocked only while it holds a result that is stalled.
    assign o_blocked = r_valid && i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (!o_blocked) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && !o_blocked) begin
            r_data <= i_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

/* rtl/guid_text_parser.sv */
// GUID text parser. Characters of a GUID text arrive one per request, and the
// request marked last yields exactly one result: valid_res with the 128-bit
// value split into guid_upper and guid_lower, or valid_res low with a zero
// value on any error. Both the plain 36-character 8-4-4-4-12 form and the
// 38-character braced form are accepted; a leading '{' selects the braced
// form. Digits may be upper or lower case, the version digit must be 1 to 5
// and the variant digit 8 to B, and any code above 127 is an error. The block
// takes one character per cycle while the input side is not stalled: a
// character sits in the input register while the checker and the shift
// register update, and a result sits in the output register until taken.
// The last character passes through the input register, and its result is
// then loaded into the output register. The input side stalls only when a last
// character is waiting and the output register still holds an untaken result.
module guid_text_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  gtp_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output gtp_pkg::t_out o_out_data
);

    // Input register stage.
    logic         r_in_valid;
    logic         n_in_valid;
    gtp_pkg::t_in r_in;

    // Parse state for the text in progress.
    logic [5:0]  r_pos;
    logic [5:0]  n_pos;
    logic        r_braced;
    logic        n_braced;
    logic        r_err;
    logic        n_err;
    logic [63:0] r_upper;
    logic [63:0] n_upper;
    logic [63:0] r_lower;
    logic [63:0] n_lower;

    gtp_pkg::t_chk chk;
    gtp_pkg::t_out result;
    logic          out_blocked;
    logic          advance;
    logic          fire;
    logic          result_load;
    logic          err_now;

    gtp_char_check u_check (
        .i_text_char (r_in.text_char),
        .i_pos       (r_pos),
        .i_braced    (r_braced),
        .o_chk       (chk)
    );

    // The held character may move on unless it is a last character whose
    // result has nowhere to go.
    assign advance     = !(r_in_valid && r_in.is_last && out_blocked);
    assign fire        = r_in_valid && advance;
    assign result_load = fire && r_in.is_last;
    assign o_in_stall  = r_in_valid && !advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (advance) begin
            n_in_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // State update for the character in the input register. A digit is
    // shifted in most significant first across the two 64-bit halves.
    always_comb begin
        n_pos    = r_pos;
        n_braced = r_braced;
        n_err    = r_err;
        n_upper  = r_upper;
        n_lower  = r_lower;
        err_now  = r_err || !chk.char_ok;
        if (chk.shift_en) begin
            n_upper = {r_upper[59:0], r_lower[63:60]};
            n_lower = {r_lower[59:0], chk.digit};
        end

        result.valid_res  = !err_now && chk.length_ok;
        result.guid_upper = result.valid_res ? n_upper : 64'd0;
        result.guid_lower = result.valid_res ? n_lower : 64'd0;

        if (fire) begin
            if (r_in.is_last) begin
                // The next character starts a fresh text.
                n_pos    = 6'd0;
                n_braced = 1'b0;
                n_err    = 1'b0;
                n_upper  = 64'd0;
                n_lower  = 64'd0;
            end else begin
                n_braced = chk.braced;
                n_err    = err_now;
                if (r_pos < gtp_pkg::POS_MAX) begin
                    n_pos = r_pos + 6'd1;
                end
            end
        end else begin
            n_upper = r_upper;
            n_lower = r_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 6'd0;
            r_braced <= 1'b0;
            r_err    <= 1'b0;
            r_upper  <= 64'd0;
            r_lower  <= 64'd0;
        end else begin
            r_pos    <= n_pos;
            r_braced <= n_braced;
            r_err    <= n_err;
            r_upper  <= n_upper;
            r_lower  <= n_lower;
        end
    end

    gtp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (result_load),
        .i_data      (result),
        .o_blocked   (out_blocked),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // A failed text never carries a value.
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.valid_res) |->
            ((o_out_data.guid_upper == 64'd0) && (o_out_data.guid_lower == 64'd0)))
        else $error("failed GUID result carries a nonzero value");

    // The input side only stalls while a character is held.
    a_stall_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in.is_last))
        else $error("input stalled without a held last character");

    // A last character that moves on always starts a fresh text and posts a result.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result_load |=> ((r_pos == 6'd0) && !r_err && !r_braced && o_out_valid))
        else $error("last character did not restart the parser");

    // A result is reported valid only for an exact-length text.
    a_valid_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (result_load && result.valid_res) |->
            ((r_pos == (gtp_pkg::BODY_LEN - 6'd1)) ||
             (r_pos == (gtp_pkg::BRACED_LEN - 6'd1))))
        else $error("valid result on a text of wrong length");

endmodule
